@@ rtl/data_row_message_parser_defines.svh @@
// Assertion macros shared by the data-row message parser RTL.
`ifndef DATA_ROW_MESSAGE_PARSER_DEFINES_SVH
`define DATA_ROW_MESSAGE_PARSER_DEFINES_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define DRP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the next cycle.
`define DRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/drp_pkg.sv @@
// Types and constants shared by the data-row message parser modules.
`timescale 1ns / 1ps

package drp_pkg;

    // Largest column count that is reported; larger counts are capped.
    localparam logic [6:0]  MAX_FIELDS     = 7'd64;
    // Fewest bytes a buffer may hold: type, 4-byte length, 2-byte count.
    localparam logic [32:0] MIN_ROW_BYTES  = 33'd7;
    // Reset value of the expected type byte.
    localparam logic [7:0]  ROW_TYPE_RESET = 8'd68;
    // Byte counts that close a 32-bit word and a 16-bit word.
    localparam logic [1:0]  WORD32_LAST    = 2'd3;
    localparam logic [1:0]  WORD16_LAST    = 2'd1;
    // Depth of the result queue.
    localparam int unsigned QUEUE_DEPTH    = 4;

    // Record kinds.
    localparam logic KIND_FIELD = 1'b0;
    localparam logic KIND_END   = 1'b1;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_BAD_TYPE  = 3'd1,
        STATUS_SHORT     = 3'd2,
        STATUS_OVERRUN   = 3'd3,
        STATUS_TRUNCATED = 3'd4
    } drp_status_t;

    typedef enum logic [2:0] {
        PH_TYPE   = 3'd0,
        PH_MSGLEN = 3'd1,
        PH_NCOLS  = 3'd2,
        PH_COLLEN = 3'd3,
        PH_DATA   = 3'd4,
        PH_DONE   = 3'd5
    } drp_phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } drp_item_t;

    typedef struct packed {
        logic        kind;
        logic [5:0]  field_index;
        logic [31:0] data_offset;
        logic [30:0] data_length;
        logic        is_null;
        logic [6:0]  column_total;
        drp_status_t status;
        logic        run_last;
    } drp_result_t;

    // Write strobes from the parser into the result queue.
    typedef struct packed {
        logic first;
        logic second;
    } drp_push_t;

    // Queue state seen by the parser and the top level.
    typedef struct packed {
        logic       room;
        logic [2:0] level;
    } drp_queue_status_t;

endpackage

@@ rtl/drp_parser.sv @@
// Input register, parse state and record building for the data-row parser.
`timescale 1ns / 1ps

module drp_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  drp_pkg::drp_item_t         item,
    input  logic                       cfg_write,
    input  logic [7:0]                 cfg_data,
    input  drp_pkg::drp_queue_status_t queue_status,
    output drp_pkg::drp_push_t         push,
    output drp_pkg::drp_result_t       rec0,
    output drp_pkg::drp_result_t       rec1
);

    import drp_pkg::*;

    // Input register.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    // Configuration register.
    logic [7:0] row_type_reg;

    // Parse state.
    drp_phase_t  phase_reg, phase_next, phase_step;
    logic [31:0] byte_position_reg, byte_position_next, byte_position_step;
    logic [31:0] word_shift_reg, word_shift_next, word_shift_step;
    logic [1:0]  word_count_reg, word_count_next, word_count_step;
    logic [31:0] message_length_reg, message_length_next, message_length_step;
    logic [6:0]  columns_wanted_reg, columns_wanted_next, columns_wanted_step;
    logic [6:0]  column_number_reg, column_number_next, column_number_step;
    logic [30:0] data_left_reg, data_left_next, data_left_step;
    logic        bad_type_reg, bad_type_next, bad_type_step;

    logic        fire;
    logic        field_done;
    logic [31:0] shift_in;
    logic [15:0] count_word;
    logic [30:0] data_left_dec;
    drp_result_t field_rec;
    drp_result_t end_rec;
    drp_status_t end_status;

    assign fire       = in_valid_reg && queue_status.room;
    assign item_ready = !in_valid_reg || queue_status.room;
    assign shift_in   = {word_shift_reg[23:0], byte_reg};
    assign count_word = shift_in[15:0];
    assign data_left_dec = data_left_reg - {30'd0, (data_left_reg != 31'd0)};

    // Input register: holds one byte until the queue can take its records.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item_valid && item_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            byte_reg <= item.data_byte;
            last_reg <= item.last;
        end
    end

    // Expected type byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_type_reg <= ROW_TYPE_RESET;
        end
        else if (cfg_write)
        begin
            row_type_reg <= cfg_data;
        end
    end

    // Effect of one byte on the parse state, before end-of-buffer clearing.
    always_comb
    begin
        phase_step          = phase_reg;
        word_shift_step     = word_shift_reg;
        word_count_step     = word_count_reg;
        message_length_step = message_length_reg;
        columns_wanted_step = columns_wanted_reg;
        column_number_step  = column_number_reg;
        data_left_step      = data_left_reg;
        bad_type_step       = bad_type_reg;
        field_done          = 1'b0;

        case (phase_reg)
            PH_TYPE:
            begin
                if (byte_reg != row_type_reg)
                begin
                    bad_type_step = 1'b1;
                    phase_step    = PH_DONE;
                end
                else
                begin
                    phase_step      = PH_MSGLEN;
                    word_shift_step = 32'd0;
                    word_count_step = 2'd0;
                end
            end
            PH_MSGLEN:
            begin
                word_shift_step = shift_in;
                if (word_count_reg == WORD32_LAST)
                begin
                    message_length_step = shift_in;
                    word_shift_step     = 32'd0;
                    word_count_step     = 2'd0;
                    phase_step          = PH_NCOLS;
                end
                else
                begin
                    word_count_step = word_count_reg + 2'd1;
                end
            end
            PH_NCOLS:
            begin
                word_shift_step = shift_in;
                if (word_count_reg == WORD16_LAST)
                begin
                    if (count_word > {9'd0, MAX_FIELDS})
                    begin
                        columns_wanted_step = MAX_FIELDS;
                    end
                    else
                    begin
                        columns_wanted_step = count_word[6:0];
                    end
                    column_number_step = 7'd0;
                    word_shift_step    = 32'd0;
                    word_count_step    = 2'd0;
                    phase_step = (columns_wanted_step == 7'd0) ? PH_DONE : PH_COLLEN;
                end
                else
                begin
                    word_count_step = word_count_reg + 2'd1;
                end
            end
            PH_COLLEN:
            begin
                word_shift_step = shift_in;
                if (word_count_reg == WORD32_LAST)
                begin
                    field_done         = 1'b1;
                    word_shift_step    = 32'd0;
                    word_count_step    = 2'd0;
                    column_number_step = column_number_reg + 7'd1;
                    if (shift_in[31])
                    begin
                        phase_step = (column_number_step >= columns_wanted_reg) ?
                                     PH_DONE : PH_COLLEN;
                    end
                    else
                    begin
                        data_left_step = shift_in[30:0];
                        if (shift_in[30:0] != 31'd0)
                        begin
                            phase_step = PH_DATA;
                        end
                        else
                        begin
                            phase_step = (column_number_step >= columns_wanted_reg) ?
                                         PH_DONE : PH_COLLEN;
                        end
                    end
                end
                else
                begin
                    word_count_step = word_count_reg + 2'd1;
                end
            end
            PH_DATA:
            begin
                data_left_step = data_left_dec;
                if (data_left_dec == 31'd0)
                begin
                    phase_step = (column_number_reg >= columns_wanted_reg) ?
                                 PH_DONE : PH_COLLEN;
                end
            end
            default:
            begin
            end
        endcase

        // Byte position saturates at its top value.
        if (byte_position_reg != 32'hFFFF_FFFF)
        begin
            byte_position_step = byte_position_reg + 32'd1;
        end
        else
        begin
            byte_position_step = byte_position_reg;
        end
    end

    // Next state: apply the step on a processed byte, clear after the last byte.
    always_comb
    begin
        phase_next          = phase_reg;
        byte_position_next  = byte_position_reg;
        word_shift_next     = word_shift_reg;
        word_count_next     = word_count_reg;
        message_length_next = message_length_reg;
        columns_wanted_next = columns_wanted_reg;
        column_number_next  = column_number_reg;
        data_left_next      = data_left_reg;
        bad_type_next       = bad_type_reg;
        if (fire)
        begin
            if (last_reg)
            begin
                phase_next          = PH_TYPE;
                byte_position_next  = 32'd0;
                word_shift_next     = 32'd0;
                word_count_next     = 2'd0;
                message_length_next = 32'd0;
                columns_wanted_next = 7'd0;
                column_number_next  = 7'd0;
                data_left_next      = 31'd0;
                bad_type_next       = 1'b0;
            end
            else
            begin
                phase_next          = phase_step;
                byte_position_next  = byte_position_step;
                word_shift_next     = word_shift_step;
                word_count_next     = word_count_step;
                message_length_next = message_length_step;
                columns_wanted_next = columns_wanted_step;
                column_number_next  = column_number_step;
                data_left_next      = data_left_step;
                bad_type_next       = bad_type_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_TYPE;
            byte_position_reg  <= 32'd0;
            word_shift_reg     <= 32'd0;
            word_count_reg     <= 2'd0;
            message_length_reg <= 32'd0;
            columns_wanted_reg <= 7'd0;
            column_number_reg  <= 7'd0;
            data_left_reg      <= 31'd0;
            bad_type_reg       <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            byte_position_reg  <= byte_position_next;
            word_shift_reg     <= word_shift_next;
            word_count_reg     <= word_count_next;
            message_length_reg <= message_length_next;
            columns_wanted_reg <= columns_wanted_next;
            column_number_reg  <= column_number_next;
            data_left_reg      <= data_left_next;
            bad_type_reg       <= bad_type_next;
        end
    end

    // End status in priority order: short, bad type, overrun, truncated.
    always_comb
    begin
        if (({1'b0, byte_position_reg} + 33'd1) < MIN_ROW_BYTES)
        begin
            end_status = STATUS_SHORT;
        end
        else if (bad_type_step)
        begin
            end_status = STATUS_BAD_TYPE;
        end
        else if (message_length_step > byte_position_reg)
        begin
            end_status = STATUS_OVERRUN;
        end
        else if ((phase_step == PH_COLLEN) || (phase_step == PH_DATA))
        begin
            end_status = STATUS_TRUNCATED;
        end
        else
        begin
            end_status = STATUS_OK;
        end
    end

    // Field and end records built from the current byte.
    always_comb
    begin
        field_rec.kind         = KIND_FIELD;
        field_rec.field_index  = column_number_reg[5:0];
        field_rec.data_offset  = shift_in[31] ? 32'd0 : (byte_position_reg + 32'd1);
        field_rec.data_length  = shift_in[31] ? 31'd0 : shift_in[30:0];
        field_rec.is_null      = shift_in[31];
        field_rec.column_total = columns_wanted_reg;
        field_rec.status       = STATUS_OK;
        field_rec.run_last     = !last_reg;

        end_rec.kind           = KIND_END;
        end_rec.field_index    = 6'd0;
        end_rec.data_offset    = 32'd0;
        end_rec.data_length    = 31'd0;
        end_rec.is_null        = 1'b0;
        end_rec.column_total   = columns_wanted_step;
        end_rec.status         = end_status;
        end_rec.run_last       = 1'b1;
    end

    // Up to two records per byte: the field record goes ahead of the end record.
    always_comb
    begin
        push.first  = fire && (field_done || last_reg);
        push.second = fire && field_done && last_reg;
        rec0        = field_done ? field_rec : end_rec;
        rec1        = end_rec;
    end

endmodule

@@ rtl/drp_result_queue.sv @@
// Result queue with two write slots per cycle and one read port.
`timescale 1ns / 1ps

module drp_result_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  drp_pkg::drp_push_t         push,
    input  drp_pkg::drp_result_t       rec0,
    input  drp_pkg::drp_result_t       rec1,
    output drp_pkg::drp_queue_status_t queue_status,
    output logic                       result_valid,
    input  logic                       result_ready,
    output drp_pkg::drp_result_t       result
);

    import drp_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    drp_result_t      entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_plus1;
    logic             pop;

    assign pop          = result_valid && result_ready;
    assign result_valid = (count_reg != '0);
    assign result       = entry_reg[rd_ptr_reg];
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);

    // Room means two free slots, enough for the most a byte can produce.
    assign queue_status.room  = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign queue_status.level = 3'(count_reg);

    // Pointer and fill-count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.first) + PTR_W'(push.second);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.first) + CNT_W'(push.second)
                      - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Record storage.
    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            entry_reg[wr_ptr_reg] <= rec0;
        end
        if (push.second)
        begin
            entry_reg[wr_ptr_plus1] <= rec1;
        end
    end

endmodule

@@ rtl/data_row_message_parser.sv @@
// Top level of the data-row message parser.
//
// Usage: bytes of a data-row buffer enter on the item channel (item_valid,
// item_ready, item), one beat per byte, with item.last set on the final byte.
// Each byte yields zero, one or two result beats on the result channel:
// a field record when a column length word completes, and an end record with
// the capped column count and a status on the last byte. Field records of a
// buffer whose end status is not ok are to be discarded by the consumer.
// The expected type byte is written on the cfg channel, which is always ready;
// write it only while no buffer is in progress.
// An accepted byte is held in the input register, and its records are written
// from there into the result queue, which drives the result channel.
// Throughput: one byte per cycle, set by the input register and a four-entry
// result queue that must have two free entries to take a byte.
// The records of a byte that yields two are read out of the queue one at a time.
// Reset clears the parse state and the queue and sets the type byte to 68.
// When the receiver stalls the queue fills, item_ready drops and bytes wait.
`timescale 1ns / 1ps
`include "data_row_message_parser_defines.svh"

module data_row_message_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  drp_pkg::drp_item_t   item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output drp_pkg::drp_result_t result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_data
);

    import drp_pkg::*;

    drp_queue_status_t queue_status;
    drp_push_t         push;
    drp_result_t       rec0;
    drp_result_t       rec1;

    // Configuration writes complete at once.
    assign cfg_ready = 1'b1;

    // Byte parser.
    drp_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .queue_status (queue_status),
        .push         (push),
        .rec0         (rec0),
        .rec1         (rec1)
    );

    // Result queue.
    drp_result_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .rec0         (rec0),
        .rec1         (rec1),
        .queue_status (queue_status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Checks.
    `DRP_ASSERT_IMPLY(a_queue_bound, clk, rst_n, push.first || push.second,
        queue_status.level <= 3'(QUEUE_DEPTH - 2), "record pushed into a full queue")
    `DRP_ASSERT_IMPLY(a_end_closes_run, clk, rst_n, result_valid && (result.kind == KIND_END),
        result.run_last, "end record without run_last")
    `DRP_ASSERT_IMPLY(a_field_status_ok, clk, rst_n,
        result_valid && (result.kind == KIND_FIELD),
        result.status == STATUS_OK, "field record carries a status")
    `DRP_ASSERT_NEXT(a_second_needs_first, clk, rst_n, push.second && !push.first,
        1'b0, "second record pushed without a first")

endmodule
